/* hw/rtl/bad_pkg.sv */
// ----------------------------------------------------------------------------
// Box area downsampler package
// Shared widths, register indexes, configuration and job types.
// ----------------------------------------------------------------------------
package bad_pkg;

   localparam int CFG_W = 13;
   localparam int DW_W = 10;
   localparam int PIX_W = 8;
   localparam int POS_W = 12;
   localparam int SUM_W = 32;
   localparam int CNT_W = 26;
   localparam int QNUM_W = 33;
   localparam int EI_W = 14;
   localparam int ENUM_W = 27;
   localparam int CH_N = 4;

   localparam logic [1:0] REG_SRC_WIDTH = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DST_WIDTH = 2'd2;
   localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

   typedef struct packed {
      logic             bypass;
      logic [CFG_W-1:0] sw;
      logic [CFG_W-1:0] sh;
      logic [DW_W-1:0]  dw;
      logic [CFG_W-1:0] dh;
   } bad_cfg_type;

   typedef struct packed {
      logic                       bypass;
      logic                       last;
      logic [POS_W-1:0]           x;
      logic [POS_W-1:0]           y;
      logic [CNT_W-1:0]           count;
      logic [CH_N-1:0][SUM_W-1:0] sum;
   } bad_job_type;

   typedef enum logic [2:0] {
      F_CLEAR,
      F_INIT_COL,
      F_INIT_ROW,
      F_IDLE,
      F_READ,
      F_UPDATE,
      F_BOUND
   } bad_front_state_type;

   typedef enum logic {
      B_IDLE,
      B_DIV
   } bad_back_state_type;

endpackage

/* hw/rtl/bad_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bad_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/bad_div.sv */
// ----------------------------------------------------------------------------
// Sequential divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bad_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      ge = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         cnt_in = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo = num_ff;
endmodule

/* hw/rtl/bad_fifo.sv */
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module bad_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bad_pkg::bad_job_type push_data,
   input  logic                 pop,
   output bad_pkg::bad_job_type pop_data,
   output logic                 full,
   output logic                 empty
);
   import bad_pkg::*;

   bad_job_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
endmodule

/* hw/rtl/bad_front.sv */
// ----------------------------------------------------------------------------
// Downsampler front end
// Accepts pixels, tracks block positions, accumulates column sums, pushes jobs (one per pixel in bypass).
// ----------------------------------------------------------------------------
module bad_front #(
   parameter int MAX_DST_WIDTH = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart,
   input  bad_pkg::bad_cfg_type cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,
   output logic                 job_push,
   output bad_pkg::bad_job_type job,
   input  logic                 q_full
);
   import bad_pkg::*;

   localparam int AW = $clog2(MAX_DST_WIDTH);
   localparam int RW = CH_N * SUM_W;

   bad_front_state_type        state_ff, state_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [CFG_W-1:0]           scol_ff, scol_in, srow_ff, srow_in, orow_ff, orow_in;
   logic [DW_W-1:0]            ocol_ff, ocol_in;
   logic [CFG_W-1:0]           cbound_ff, cbound_in, rbound_ff, rbound_in;
   logic [CFG_W-1:0]           cstart_ff, cstart_in, bstart_ff, bstart_in;
   logic [CFG_W-1:0]           fcol_ff, fcol_in, frow_ff, frow_in;
   logic                       brow_ff, brow_in;
   logic [31:0]                pix_ff, pix_in;
   logic [CH_N-1:0][SUM_W-1:0] sums_ff, sums_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       lc_ff, lc_in, lr_ff, lr_in, emit_ff, emit_in;
   logic                       bce_reg, bend_reg;
   logic                       lc, lr, bce, bend;
   logic [CFG_W-1:0]           cw, rh;
   logic                       accept;
   logic                       ram_we, ram_re;
   logic [RW-1:0]              ram_wd, ram_rd;
   logic                       div_start, div_done;
   logic [EI_W-1:0]            div_i;
   logic [CFG_W-1:0]           div_s, div_d;
   logic [ENUM_W-1:0]          div_q;

   bad_ram #(.WIDTH(RW), .DEPTH(MAX_DST_WIDTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(state_ff == F_CLEAR ? clr_ff : AW'(ocol_ff)),
      .wr_data(ram_wd), .rd_en(ram_re), .rd_addr(AW'(ocol_ff)), .rd_data(ram_rd)
   );

   bad_div #(.NUM_W(ENUM_W), .DEN_W(CFG_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num({13'd0, div_i} * {14'd0, div_s}), .den(div_d), .done(div_done), .quo(div_q)
   );

   always_comb begin
      accept = req_tvalid && req_tready;
      lc = ({1'b0, scol_ff} + 1'b1) >= {1'b0, cfg.sw};
      lr = ({1'b0, srow_ff} + 1'b1) >= {1'b0, cfg.sh};
      bce = (({1'b0, scol_ff} + 1'b1) >= {1'b0, cbound_ff}) || lc;
      bend = (({1'b0, srow_ff} + 1'b1) >= {1'b0, rbound_ff}) || lr;
      cw = (cbound_ff > cstart_ff) ? cbound_ff - cstart_ff : CFG_W'(1);
      rh = (rbound_ff > bstart_ff) ? rbound_ff - bstart_ff : CFG_W'(1);
      for (int k = 0; k < CH_N; k++) begin
         sums_in[k] = ram_rd[k*SUM_W +: SUM_W] + {24'd0, pix_ff[k*PIX_W +: PIX_W]};
      end
      count_in = {13'd0, cw} * {13'd0, rh};
      lc_in = lc;
      lr_in = lr;
      emit_in = bce && bend;
      state_in = state_ff;
      clr_in = clr_ff;
      scol_in = scol_ff;
      srow_in = srow_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      cbound_in = cbound_ff;
      rbound_in = rbound_ff;
      cstart_in = cstart_ff;
      bstart_in = bstart_ff;
      fcol_in = fcol_ff;
      frow_in = frow_ff;
      brow_in = brow_ff;
      pix_in = pix_ff;
      req_tready = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_wd = '0;
      div_start = 1'b0;
      div_i = EI_W'(1);
      div_s = cfg.sw;
      div_d = CFG_W'(cfg.dw);
      job_push = 1'b0;
      job.bypass = 1'b0;
      job.last = lc_ff && lr_ff;
      job.x = POS_W'(ocol_ff);
      job.y = orow_ff[POS_W-1:0];
      job.count = count_ff;
      job.sum = sums_ff;
      unique case (state_ff)
         F_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_DST_WIDTH - 1)) begin
               if (cfg.bypass) begin
                  cbound_in = CFG_W'(1);
                  rbound_in = CFG_W'(1);
                  state_in = F_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in = F_INIT_COL;
               end
            end
         end
         F_INIT_COL: begin
            if (div_done) begin
               cbound_in = div_q[CFG_W-1:0];
               fcol_in = div_q[CFG_W-1:0];
               div_start = 1'b1;
               div_s = cfg.sh;
               div_d = cfg.dh;
               state_in = F_INIT_ROW;
            end
         end
         F_INIT_ROW: begin
            if (div_done) begin
               rbound_in = div_q[CFG_W-1:0];
               frow_in = div_q[CFG_W-1:0];
               state_in = F_IDLE;
            end
         end
         F_IDLE: begin
            req_tready = !q_full;
            if (accept) begin
               pix_in = req_tdata;
               if (cfg.bypass) begin
                  job_push = 1'b1;
                  job.bypass = 1'b1;
                  job.last = lc && lr;
                  job.x = scol_ff[POS_W-1:0];
                  job.y = srow_ff[POS_W-1:0];
                  for (int k = 0; k < CH_N; k++) begin
                     job.sum[k] = {24'd0, req_tdata[k*PIX_W +: PIX_W]};
                  end
                  if (lc) begin
                     scol_in = '0;
                     srow_in = lr ? '0 : srow_ff + 1'b1;
                  end else begin
                     scol_in = scol_ff + 1'b1;
                  end
               end else begin
                  ram_re = 1'b1;
                  state_in = F_READ;
               end
            end
         end
         F_READ: begin
            state_in = F_UPDATE;
         end
         F_UPDATE: begin
            if (!(emit_ff && q_full)) begin
               ram_we = 1'b1;
               ram_wd = emit_ff ? '0 : sums_ff;
               job_push = emit_ff;
               state_in = F_IDLE;
               if (!lc_ff) begin
                  scol_in = scol_ff + 1'b1;
                  if (bce_reg && ({1'b0, ocol_ff} + 1'b1) < {1'b0, cfg.dw}) begin
                     ocol_in = ocol_ff + 1'b1;
                     cstart_in = cbound_ff;
                     div_start = 1'b1;
                     div_i = EI_W'(ocol_ff) + EI_W'(2);
                     brow_in = 1'b0;
                     state_in = F_BOUND;
                  end
               end else begin
                  scol_in = '0;
                  ocol_in = '0;
                  cstart_in = '0;
                  cbound_in = fcol_ff;
                  if (!bend_reg) begin
                     srow_in = srow_ff + 1'b1;
                  end else if (lr_ff || ({1'b0, orow_ff} + 1'b1) >= {1'b0, cfg.dh}) begin
                     srow_in = '0;
                     orow_in = '0;
                     bstart_in = '0;
                     rbound_in = frow_ff;
                  end else begin
                     srow_in = srow_ff + 1'b1;
                     orow_in = orow_ff + 1'b1;
                     bstart_in = srow_ff + 1'b1;
                     div_start = 1'b1;
                     div_i = EI_W'(orow_ff) + EI_W'(2);
                     div_s = cfg.sh;
                     div_d = cfg.dh;
                     brow_in = 1'b1;
                     state_in = F_BOUND;
                  end
               end
            end
         end
         F_BOUND: begin
            if (div_done) begin
               if (brow_ff) begin
                  rbound_in = div_q[CFG_W-1:0];
               end else begin
                  cbound_in = div_q[CFG_W-1:0];
               end
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_CLEAR;
         end
      endcase
      if (restart) begin
         state_in = F_CLEAR;
         clr_in = '0;
         scol_in = '0;
         srow_in = '0;
         ocol_in = '0;
         orow_in = '0;
         cstart_in = '0;
         bstart_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_CLEAR;
         clr_ff <= '0;
         scol_ff <= '0;
         srow_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         cstart_ff <= '0;
         bstart_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         scol_ff <= scol_in;
         srow_ff <= srow_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
         cstart_ff <= cstart_in;
         bstart_ff <= bstart_in;
      end
      cbound_ff <= cbound_in;
      rbound_ff <= rbound_in;
      fcol_ff <= fcol_in;
      frow_ff <= frow_in;
      brow_ff <= brow_in;
      pix_ff <= pix_in;
      if (state_ff == F_READ) begin
         sums_ff <= sums_in;
         count_ff <= count_in;
         lc_ff <= lc_in;
         lr_ff <= lr_in;
         emit_ff <= emit_in;
         bce_reg <= bce;
         bend_reg <= bend;
      end
   end
endmodule

/* hw/rtl/bad_back.sv */
// ----------------------------------------------------------------------------
// Downsampler back end
// Divides block sums by pixel counts and holds the result request.
// ----------------------------------------------------------------------------
module bad_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  bad_pkg::bad_job_type job,
   output logic                 job_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,
   output logic                 rsp_tlast
);
   import bad_pkg::*;

   bad_back_state_type         state_ff, state_in;
   logic                       out_valid_ff, out_valid_in;
   logic [55:0]                out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in;
   logic [POS_W-1:0]           x_ff, x_in, y_ff, y_in;
   logic                       last_ff, last_in;
   logic                       free, start;
   logic [CH_N-1:0]            done;
   logic [CH_N-1:0][QNUM_W-1:0] quo;

   for (genvar k = 0; k < CH_N; k++) begin : g_div
      bad_div #(.NUM_W(QNUM_W), .DEN_W(CNT_W)) u_div (
         .clock(clock), .reset(reset), .start(start),
         .num({1'b0, job.sum[k]} + QNUM_W'(job.count >> 1)),
         .den(job.count), .done(done[k]), .quo(quo[k])
      );
   end

   always_comb begin
      free = !out_valid_ff || rsp_tready;
      state_in = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      x_in = x_ff;
      y_in = y_ff;
      last_in = last_ff;
      job_pop = 1'b0;
      start = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid && free) begin
               job_pop = 1'b1;
               if (job.bypass) begin
                  out_valid_in = 1'b1;
                  out_data_in = {job.y, job.x, job.sum[3][7:0], job.sum[2][7:0],
                                 job.sum[1][7:0], job.sum[0][7:0]};
                  out_last_in = job.last;
               end else begin
                  start = 1'b1;
                  x_in = job.x;
                  y_in = job.y;
                  last_in = job.last;
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            if (done[0]) begin
               out_valid_in = 1'b1;
               out_data_in = {y_ff, x_ff, quo[3][7:0], quo[2][7:0], quo[1][7:0], quo[0][7:0]};
               out_last_in = last_ff;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      x_ff <= x_in;
      y_ff <= y_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;
endmodule

/* hw/rtl/box_area_downsampler_core.sv */
// ----------------------------------------------------------------------------
// Box area downsampler core
// Shrinks a raster stream of premultiplied ARGB pixels by area averaging.
// ----------------------------------------------------------------------------
// Source pixels arrive on the req_ stream, one request per pixel in raster
// order; averaged output pixels leave on the rsp_ stream, with rsp_tlast set
// on the last pixel of the image. The csr_ port holds the source and target
// sizes; every write restarts the frame.
// After reset and after every register write the column sum memory is
// cleared and, outside bypass, the first block bounds are divided out;
// req_tready stays low meanwhile. In bypass a pixel is taken every cycle
// while the queue has room and reaches rsp_ through the job queue and the
// back end's output register. Otherwise a pixel passes the F_READ and
// F_UPDATE states for the sum read-modify-write, and F_BOUND as well when
// it closes a block column or a band and needs the next bound division.
// A finished block waits in the back-end divider; the two-entry queue
// lets the front carry on meanwhile. When the receiver stalls, the result
// is held, the queue fills and req_tready drops.
// ----------------------------------------------------------------------------
module box_area_downsampler_core #(
   parameter int MAX_DST_WIDTH = 512,
   parameter int MAX_SRC_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // alpha_in, red_in, green_in, blue_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // alpha_out, red_out, green_out, blue_out, out_x, out_y
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bad_pkg::*;

   logic [CFG_W-1:0] sw_ff, sw_in, sh_ff, sh_in, dh_ff, dh_in;
   logic [DW_W-1:0]  dw_ff, dw_in;
   logic             wr;
   logic [CFG_W-1:0] sw1, sh1, dh1, dwr1;
   bad_cfg_type      cfg;
   logic             job_push, job_pop, q_full, q_empty;
   bad_job_type      job_in, job_out;

   always_comb begin
      wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
      sw_in = sw_ff;
      sh_in = sh_ff;
      dw_in = dw_ff;
      dh_in = dh_ff;
      if (wr) begin
         unique case (csr_paddr[3:2])
            REG_SRC_WIDTH: sw_in = csr_pwdata[CFG_W-1:0];
            REG_SRC_HEIGHT: sh_in = csr_pwdata[CFG_W-1:0];
            REG_DST_WIDTH: dw_in = csr_pwdata[DW_W-1:0];
            REG_DST_HEIGHT: dh_in = csr_pwdata[CFG_W-1:0];
            default: sw_in = sw_ff;
         endcase
      end
      unique case (csr_paddr[3:2])
         REG_SRC_WIDTH: csr_prdata = {19'd0, sw_ff};
         REG_SRC_HEIGHT: csr_prdata = {19'd0, sh_ff};
         REG_DST_WIDTH: csr_prdata = {22'd0, dw_ff};
         REG_DST_HEIGHT: csr_prdata = {19'd0, dh_ff};
         default: csr_prdata = '0;
      endcase
      sw1 = (sw_ff == '0) ? CFG_W'(1) : sw_ff;
      sh1 = (sh_ff == '0) ? CFG_W'(1) : sh_ff;
      dh1 = (dh_ff == '0) ? CFG_W'(1) : dh_ff;
      dwr1 = (dw_ff == '0) ? CFG_W'(1) : CFG_W'(dw_ff);
      cfg.sw = (32'(sw1) > MAX_SRC_DIM) ? CFG_W'(MAX_SRC_DIM) : sw1;
      cfg.sh = (32'(sh1) > MAX_SRC_DIM) ? CFG_W'(MAX_SRC_DIM) : sh1;
      cfg.dw = (32'(dwr1) > MAX_DST_WIDTH) ? DW_W'(MAX_DST_WIDTH) : DW_W'(dwr1);
      cfg.dh = (dh1 > cfg.sh) ? cfg.sh : dh1;
      cfg.bypass = dwr1 >= cfg.sw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= CFG_W'(1);
         sh_ff <= CFG_W'(1);
         dw_ff <= DW_W'(1);
         dh_ff <= CFG_W'(1);
      end else begin
         sw_ff <= sw_in;
         sh_ff <= sh_in;
         dw_ff <= dw_in;
         dh_ff <= dh_in;
      end
   end

   assign csr_pready = 1'b1;

   bad_front #(.MAX_DST_WIDTH(MAX_DST_WIDTH)) u_front (
      .clock(clock), .reset(reset), .restart(wr), .cfg(cfg),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .job_push(job_push), .job(job_in), .q_full(q_full)
   );

   bad_fifo u_fifo (
      .clock(clock), .reset(reset), .push(job_push), .push_data(job_in),
      .pop(job_pop), .pop_data(job_out), .full(q_full), .empty(q_empty)
   );

   bad_back u_back (
      .clock(clock), .reset(reset), .job_valid(!q_empty), .job(job_out), .job_pop(job_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );
endmodule

/* hw/rtl/bad_core_checker.sv */
// ----------------------------------------------------------------------------
// Box area downsampler checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
module bad_core_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result request changed while stalled");

   a_write_blocks: assert property (@(posedge clock)
      csr_psel && csr_penable && csr_pwrite && csr_pready |=> !req_tready)
      else $error("request taken during the clearing pass");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("activity straight after reset");
endmodule

bind box_area_downsampler_core bad_core_checker u_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box area downsampler core testbench
// Streams raster frames of random ARGB pixels through the core
// under a range of source and target sizes, bypass included, and checks
// every output pixel against an area-averaging model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
   import bad_pkg::*;

   localparam int SUM_DEPTH = 512;
   localparam int DIM_MAX = 4096;
   localparam int ITEM_GOAL = 400;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [7:0]  a, r, g, b;
      logic [11:0] x, y;
      logic        fe;
   } out_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // alpha_in, red_in, green_in, blue_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // alpha_out, red_out, green_out, blue_out, out_x, out_y
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   box_area_downsampler_core u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Size registers and the block's running state.
   logic [12:0] reg_sw = 13'd1, reg_sh = 13'd1, reg_dh = 13'd1;
   logic [9:0]  reg_dw = 10'd1;
   longint unsigned col_sum [4][SUM_DEPTH];
   int unsigned src_col, src_row, dst_col, dst_row, col_end, row_end, band_top;

   logic [31:0]   pixel_queue [$];
   out_pixel_type expected_pixels [$];
   int            sender_idle = 38, receiver_idle = 72;
   int            failures = 0, pixels_in = 0, pixels_out = 0, frames_seen = 0;
   int            settings_used = 0;
   int            cycle_count = 0;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) v = 1;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic int unsigned eff_sw();
      return clamp_dim(reg_sw, DIM_MAX);
   endfunction

   function automatic int unsigned eff_sh();
      return clamp_dim(reg_sh, DIM_MAX);
   endfunction

   function automatic int unsigned eff_dw();
      return clamp_dim(reg_dw, SUM_DEPTH);
   endfunction

   function automatic int unsigned eff_dh();
      return clamp_dim(reg_dh, eff_sh());
   endfunction

   function automatic bit passes_through();
      return clamp_dim(reg_dw, 32'hFFFF_FFFF) >= eff_sw();
   endfunction

   function automatic int unsigned bound_at(int unsigned i, int unsigned s, int unsigned d);
      longint unsigned p;
      p = longint'(i) * s;
      return int'(p / d);
   endfunction

   function automatic logic [7:0] rounded_mean(longint unsigned s, longint unsigned n);
      return 8'((s + n / 2) / n);
   endfunction

   task automatic restart_frame();
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < SUM_DEPTH; i++) col_sum[c][i] = 0;
      src_col = 0; src_row = 0; dst_col = 0; dst_row = 0; band_top = 0;
      if (passes_through()) begin
         col_end = 1; row_end = 1;
      end else begin
         col_end = bound_at(1, eff_sw(), eff_dw());
         row_end = bound_at(1, eff_sh(), eff_dh());
      end
   endtask

   task automatic downsample_pixel(logic [31:0] d);
      int unsigned sw, sh, dw, dh, ox, x0;
      bit last_col, last_row, col_done, band_done;
      longint unsigned cw, rh;
      logic [7:0] ch [4];
      out_pixel_type o;
      ch[0] = d[7:0]; ch[1] = d[15:8]; ch[2] = d[23:16]; ch[3] = d[31:24];
      sw = eff_sw(); sh = eff_sh();
      last_col = (src_col + 1 >= sw);
      last_row = (src_row + 1 >= sh);
      if (passes_through()) begin
         o = '{ch[0], ch[1], ch[2], ch[3], 12'(src_col), 12'(src_row), last_col && last_row};
         expected_pixels.push_back(o);
         if (last_col) begin
            src_col = 0;
            src_row = last_row ? 0 : src_row + 1;
         end else begin
            src_col++;
         end
         return;
      end
      dw = eff_dw(); dh = eff_dh();
      ox = (dst_col >= SUM_DEPTH) ? SUM_DEPTH - 1 : dst_col;
      for (int c = 0; c < 4; c++) col_sum[c][ox] += ch[c];
      col_done = (src_col + 1 >= col_end) || last_col;
      band_done = (src_row + 1 >= row_end) || last_row;
      if (col_done && band_done) begin
         x0 = bound_at(ox, sw, dw);
         cw = (col_end > x0) ? col_end - x0 : 1;
         rh = (row_end > band_top) ? row_end - band_top : 1;
         o.a = rounded_mean(col_sum[0][ox], cw * rh);
         o.r = rounded_mean(col_sum[1][ox], cw * rh);
         o.g = rounded_mean(col_sum[2][ox], cw * rh);
         o.b = rounded_mean(col_sum[3][ox], cw * rh);
         o.x = 12'(ox);
         o.y = 12'(dst_row);
         o.fe = last_col && last_row;
         expected_pixels.push_back(o);
         for (int c = 0; c < 4; c++) col_sum[c][ox] = 0;
      end
      if (!last_col) begin
         if (col_done && ox + 1 < dw) begin
            dst_col = ox + 1;
            col_end = bound_at(dst_col + 1, sw, dw);
         end
         src_col++;
         return;
      end
      src_col = 0;
      dst_col = 0;
      col_end = bound_at(1, sw, dw);
      if (!band_done) begin
         src_row++;
         return;
      end
      if (last_row || dst_row + 1 >= dh) begin
         src_row = 0; dst_row = 0; band_top = 0;
         row_end = bound_at(1, sh, dh);
      end else begin
         src_row++;
         dst_row++;
         band_top = src_row;
         row_end = bound_at(dst_row + 1, sh, dh);
      end
   endtask

   // Request driver; each accepted pixel is predicted at its handshake.
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            downsample_pixel(req_tdata);
            pixels_in++;
            next_valid = 1'b0;
         end
         if (!next_valid && pixel_queue.size() > 0 &&
             $urandom_range(99) >= sender_idle) begin
            req_tdata <= pixel_queue.pop_front();
            next_valid = 1'b1;
         end
      end
      req_tvalid <= next_valid;
   end

   // Response monitor and back-pressure.
   always @(posedge clock) begin
      out_pixel_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_out++;
         if (rsp_tlast) frames_seen++;
         if (expected_pixels.size() == 0) begin
            $error("Unexpected output pixel %h", rsp_tdata);
            failures++;
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== e.a) begin
               $error("alpha_out: expected %0d, got %0d", e.a, rsp_tdata[7:0]);
               failures++;
            end
            if (rsp_tdata[15:8] !== e.r) begin
               $error("red_out: expected %0d, got %0d", e.r, rsp_tdata[15:8]);
               failures++;
            end
            if (rsp_tdata[23:16] !== e.g) begin
               $error("green_out: expected %0d, got %0d", e.g, rsp_tdata[23:16]);
               failures++;
            end
            if (rsp_tdata[31:24] !== e.b) begin
               $error("blue_out: expected %0d, got %0d", e.b, rsp_tdata[31:24]);
               failures++;
            end
            if (rsp_tdata[43:32] !== e.x) begin
               $error("out_x: expected %0d, got %0d", e.x, rsp_tdata[43:32]);
               failures++;
            end
            if (rsp_tdata[55:44] !== e.y) begin
               $error("out_y: expected %0d, got %0d", e.y, rsp_tdata[55:44]);
               failures++;
            end
            if (rsp_tlast !== e.fe) begin
               $error("frame_end: expected %0d, got %0d", e.fe, rsp_tlast);
               failures++;
            end
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= receiver_idle);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_SRC_WIDTH:  reg_sw = value[12:0];
         REG_SRC_HEIGHT: reg_sh = value[12:0];
         REG_DST_WIDTH:  reg_dw = value[9:0];
         REG_DST_HEIGHT: reg_dh = value[12:0];
      endcase
      restart_frame();
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   function automatic logic [7:0] random_channel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic set_pacing();
      if (pixels_in + pixel_queue.size() < ITEM_GOAL / 3) begin
         sender_idle = 38; receiver_idle = 72;
      end else if (pixels_in + pixel_queue.size() < 2 * ITEM_GOAL / 3) begin
         sender_idle = 72; receiver_idle = 38;
      end else begin
         sender_idle = 0; receiver_idle = 0;
      end
   endtask

   task automatic drain();
      while (pixel_queue.size() > 0 || req_tvalid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic run_setting(int sw, int sh, int dw, int dh, int n);
      drain();
      write_csr(REG_SRC_WIDTH, sw);
      write_csr(REG_SRC_HEIGHT, sh);
      write_csr(REG_DST_WIDTH, dw);
      write_csr(REG_DST_HEIGHT, dh);
      settings_used++;
      set_pacing();
      for (int i = 0; i < n; i++)
         pixel_queue.push_back({random_channel(), random_channel(),
                                random_channel(), random_channel()});
   endtask

   initial begin
      int sw, sh, n;
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      pixel_queue.push_back(32'h0000_0000);
      pixel_queue.push_back(32'hFFFF_FFFF);
      pixel_queue.push_back(32'hAAAA_AAAA);
      pixel_queue.push_back(32'h5555_5555);
      run_setting(5, 3, 5, 1, 15);
      run_setting(0, 0, 0, 0, 3);
      run_setting(8191, 1, 1023, 8191, 40);
      run_setting(7, 5, 3, 2, 35);
      run_setting(10, 4, 4, 9, 40);
      while (pixels_in + pixel_queue.size() < ITEM_GOAL) begin
         sw = $urandom_range(2, 12);
         sh = $urandom_range(1, 8);
         n = sw * sh * $urandom_range(1, 2);
         if ($urandom_range(3) == 0) n += $urandom_range(1, sw);
         if (pixels_in + n > ITEM_GOAL + 20) n = ITEM_GOAL + 20 - pixels_in;
         run_setting(sw, sh, $urandom_range(1, sw), $urandom_range(0, 10), n);
      end
      drain();
      $display("Ran %0d size settings: %0d source pixels in, %0d output pixels, %0d frames.",
               settings_used, pixels_in, pixels_out, frames_seen);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
